// File: hw/rtl/temporal_still_pixel_blend_macros.svh
// assertion macros used by the top-level rtl
`ifndef TEMPORAL_STILL_PIXEL_BLEND_MACROS_SVH
`define TEMPORAL_STILL_PIXEL_BLEND_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tspb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TSPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspb assertion failed");

`endif

// File: hw/rtl/tspb_pkg.sv
package tspb_pkg;

  localparam int MAX_PIXELS   = 16384;
  localparam int HISTORY_LOG2 = 6;

  localparam int HIST_PLANES = 1 << HISTORY_LOG2;
  localparam int POS_W       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PLANE_W     = HISTORY_LOG2;
  localparam int HIST_DEPTH  = MAX_PIXELS * HIST_PLANES;
  localparam int HADDR_W     = $clog2(HIST_DEPTH);

  localparam int PIX_W  = 24;
  localparam int LUMA_W = 8;
  localparam int SUM_W  = LUMA_W + HISTORY_LOG2;
  localparam int FP_W   = 15;
  localparam int CFG_W  = 15;
  localparam int CNT_W  = ((FP_W > POS_W) ? FP_W : POS_W) + 1;

  localparam int MOTION_GAIN_LOG2 = 3;
  localparam int WEIGHT_MAX       = 255;
  localparam int SUM_MAX          = ((1 << LUMA_W) - 1) << HISTORY_LOG2;
  localparam int FP_RESET         = 16384;

  typedef enum logic [0:0] {
    REG_MODE         = 1'b0,
    REG_FRAME_PIXELS = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    MODE_DISAPPEAR = 1'b0,
    MODE_APPEAR    = 1'b1
  } mode_t;

  // accept stage to read-modify-write stage
  typedef struct packed {
    logic               valid;
    logic [PIX_W-1:0]   px;
    logic [POS_W-1:0]   pos;
    logic [HADDR_W-1:0] hidx;
    logic [LUMA_W-1:0]  luma;
    logic               captured;
  } s1_t;

  // read-modify-write stage to weight stage
  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  bg;
    logic [LUMA_W-1:0] luma;
    logic [SUM_W-1:0]  sum;
  } s2_t;

  // weight stage to blend
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] bg;
    logic [7:0]       w;
  } s3_t;

  typedef struct packed {
    logic               we;
    logic [HADDR_W-1:0] addr;
    logic [LUMA_W-1:0]  data;
  } hist_wr_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] addr;
    logic [SUM_W-1:0] data;
  } sum_wr_t;

  typedef struct packed {
    logic               busy;
    logic [HADDR_W-1:0] hist_addr;
    logic               sum_we;
    logic [POS_W-1:0]   sum_addr;
  } clr_t;

endpackage

// File: hw/rtl/tspb_ram.sv
module tspb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tspb_clear.sv
module tspb_clear import tspb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  output clr_t clr
);

  logic               busy_r, busy_nxt;
  logic [HADDR_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + HADDR_W'(1);
      if (cnt_r == HADDR_W'(HIST_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // sums only cover the first plane's worth of addresses
  assign clr.busy      = busy_r;
  assign clr.hist_addr = cnt_r;
  assign clr.sum_we    = busy_r && (cnt_r < HADDR_W'(MAX_PIXELS));
  assign clr.sum_addr  = cnt_r[POS_W-1:0];

endmodule

// File: hw/rtl/tspb_accum.sv
module tspb_accum import tspb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  s1_t               s1,
  input  logic [LUMA_W-1:0] hist_rd,
  input  logic [SUM_W-1:0]  sum_rd,
  input  logic [PIX_W-1:0]  bg_rd,
  output hist_wr_t          hist_wr,
  output sum_wr_t           sum_wr,
  output s2_t               s2
);

  logic             fwd_valid_r;
  logic [POS_W-1:0] fwd_pos_r;
  logic [SUM_W-1:0] fwd_sum_r;
  logic [SUM_W-1:0] sum_cur, sum_new;
  logic             wr_en;
  s2_t              s2_r;

  // last sum write may not be visible in the ram read yet
  assign sum_cur = (fwd_valid_r && (fwd_pos_r == s1.pos)) ? fwd_sum_r : sum_rd;
  assign sum_new = sum_cur - SUM_W'(hist_rd) + SUM_W'(s1.luma);
  assign wr_en   = s1.valid && advance;

  assign hist_wr.we   = wr_en;
  assign hist_wr.addr = s1.hidx;
  assign hist_wr.data = s1.luma;
  assign sum_wr.we    = wr_en;
  assign sum_wr.addr  = s1.pos;
  assign sum_wr.data  = sum_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_pos_r <= s1.pos;
      fwd_sum_r <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (advance) begin
      s2_r.valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      s2_r.px   <= s1.px;
      s2_r.bg   <= s1.captured ? bg_rd : s1.px;
      s2_r.luma <= s1.luma;
      s2_r.sum  <= sum_new;
    end
  end

  assign s2 = s2_r;

endmodule

// File: hw/rtl/tspb_mix.sv
module tspb_mix import tspb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  s2_t              s2,
  input  mode_t            mode,
  input  logic             out_ready,
  output logic             advance,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel_out
);

  localparam int WIDE_W = SUM_W + MOTION_GAIN_LOG2;

  s3_t              s3_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_load;
  logic [SUM_W-1:0] scaled, diff;
  logic [WIDE_W-1:0] wide;
  logic [7:0]       w_nxt;
  logic [PIX_W-1:0] from_px, to_px, blend_nxt;

  // from + floor((to - from) * w / 256), modulo 256
  function automatic logic [7:0] blend_ch(input logic [7:0] from, input logic [7:0] to,
                                          input logic [7:0] w);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    d = $signed({1'b0, to}) - $signed({1'b0, from});
    p = d * $signed({1'b0, w});
    return from + p[15:8];
  endfunction

  assign out_load = !out_valid_r || out_ready;
  assign advance  = out_load || !s3_r.valid;

  assign scaled = {s2.luma, {HISTORY_LOG2{1'b0}}};
  assign diff   = (scaled >= s2.sum) ? (scaled - s2.sum) : (s2.sum - scaled);
  assign wide   = {diff, {MOTION_GAIN_LOG2{1'b0}}} >> HISTORY_LOG2;
  assign w_nxt  = (wide > WIDE_W'(WEIGHT_MAX)) ? 8'(WEIGHT_MAX) : wide[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (advance) begin
      s3_r.valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2.valid) begin
      s3_r.px <= s2.px;
      s3_r.bg <= s2.bg;
      s3_r.w  <= w_nxt;
    end
  end

  always_comb begin
    if (mode == MODE_DISAPPEAR) begin
      from_px = s3_r.bg;
      to_px   = s3_r.px;
    end else begin
      from_px = s3_r.px;
      to_px   = s3_r.bg;
    end
    blend_nxt = {blend_ch(from_px[23:16], to_px[23:16], s3_r.w),
                 blend_ch(from_px[15:8],  to_px[15:8],  s3_r.w),
                 blend_ch(from_px[7:0],   to_px[7:0],   s3_r.w)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s3_r.valid) begin
      out_pixel_r <= blend_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

// File: hw/rtl/temporal_still_pixel_blend.sv
// pipeline: accept, read-modify-write, weight and output registers, in that order
// throughput: one item per cycle unless out_ready stalls, set by the sum ram
//   read-modify-write with forwarding of the last sum written
// reset: synchronous, active low; afterwards a clearing pass zeroes the luma
//   history and sums, in_ready stays low until it is done
`include "temporal_still_pixel_blend_macros.svh"

module temporal_still_pixel_blend import tspb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel_out,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // configuration
  mode_t             mode_r;
  logic [FP_W-1:0]   fp_r;

  // frame walk
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic               captured_r, captured_nxt;

  s1_t   s1_r;
  s2_t   s2;
  clr_t  clr;
  hist_wr_t hist_wr;
  sum_wr_t  sum_wr;

  logic               advance, acc;
  logic [9:0]         luma_acc;
  logic [LUMA_W-1:0]  luma;
  logic [CNT_W-1:0]   pos_inc, n_eff;
  logic               frame_end;
  logic [HADDR_W-1:0] hidx;

  logic [LUMA_W-1:0]  hist_rd;
  logic [SUM_W-1:0]   sum_rd;
  logic [PIX_W-1:0]   bg_rd;

  // ram write ports, clearing pass has priority
  logic               hist_we, sum_we;
  logic [HADDR_W-1:0] hist_waddr;
  logic [LUMA_W-1:0]  hist_wdata;
  logic [POS_W-1:0]   sum_waddr;
  logic [SUM_W-1:0]   sum_wdata;

  // config writes, only while idle; the user is bound, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DISAPPEAR;
      fp_r   <= FP_W'(FP_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:         mode_r <= mode_t'(cfg_wdata[0]);
        REG_FRAME_PIXELS: fp_r   <= cfg_wdata[FP_W-1:0];
        default: ;
      endcase
    end
  end

  // accept stage
  assign in_ready = advance && !clr.busy;
  assign acc      = in_valid && in_ready;

  // luma is (r + 2g + b) >> 2
  assign luma_acc = 10'(in_pixel_in[23:16]) + {1'b0, in_pixel_in[15:8], 1'b0}
                  + 10'(in_pixel_in[7:0]);
  assign luma     = luma_acc[9:2];

  // frame size clamped to 1..MAX_PIXELS
  always_comb begin
    if (fp_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(fp_r) > CNT_W'(MAX_PIXELS)) begin
      n_eff = CNT_W'(MAX_PIXELS);
    end else begin
      n_eff = CNT_W'(fp_r);
    end
  end

  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  // a position already past the frame size ends the frame too
  assign frame_end = (pos_inc >= n_eff);

  // each plane holds MAX_PIXELS entries
  assign hidx = HADDR_W'(plane_r) * HADDR_W'(MAX_PIXELS) + HADDR_W'(pos_r);

  always_comb begin
    pos_nxt      = pos_r;
    plane_nxt    = plane_r;
    captured_nxt = captured_r;
    if (acc) begin
      if (frame_end) begin
        pos_nxt      = '0;
        plane_nxt    = plane_r + PLANE_W'(1);
        captured_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      plane_r    <= '0;
      captured_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      plane_r    <= plane_nxt;
      captured_r <= captured_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (advance) begin
      s1_r.valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.px       <= in_pixel_in;
      s1_r.pos      <= pos_r;
      s1_r.hidx     <= hidx;
      s1_r.luma     <= luma;
      s1_r.captured <= captured_r;
    end
  end

  // clearing pass after reset
  tspb_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  assign hist_we    = clr.busy || hist_wr.we;
  assign hist_waddr = clr.busy ? clr.hist_addr : hist_wr.addr;
  assign hist_wdata = clr.busy ? '0 : hist_wr.data;
  assign sum_we     = clr.busy ? clr.sum_we : sum_wr.we;
  assign sum_waddr  = clr.busy ? clr.sum_addr : sum_wr.addr;
  assign sum_wdata  = clr.busy ? '0 : sum_wr.data;

  // luma history, one plane per frame of the last 2^HISTORY_LOG2
  tspb_ram #(.WIDTH(LUMA_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (acc),
    .raddr (hidx),
    .rdata (hist_rd)
  );

  // running luma sum per position
  tspb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_PIXELS)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (acc),
    .raddr (pos_r),
    .rdata (sum_rd)
  );

  // background, written during the capture frame at accept time
  tspb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_bg_ram (
    .clk   (clk),
    .we    (acc && !captured_r),
    .waddr (pos_r),
    .wdata (in_pixel_in),
    .re    (acc),
    .raddr (pos_r),
    .rdata (bg_rd)
  );

  // sum update and history write-back
  tspb_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .s1      (s1_r),
    .hist_rd (hist_rd),
    .sum_rd  (sum_rd),
    .bg_rd   (bg_rd),
    .hist_wr (hist_wr),
    .sum_wr  (sum_wr),
    .s2      (s2)
  );

  // motion weight, blend and output register
  tspb_mix u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .s2            (s2),
    .mode          (mode_r),
    .out_ready     (out_ready),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out)
  );

  // no item may reach the write-back stage while the clearing pass runs
  `TSPB_ASSERT_NOW(a_no_item_in_clear, clr.busy, !s1_r.valid && !hist_wr.we)
  // the running sum never leaves the range of 2^HISTORY_LOG2 lumas
  `TSPB_ASSERT_NOW(a_sum_range, s2.valid, s2.sum <= SUM_W'(SUM_MAX))
  // capture ends only on a frame end, which also steps the plane
  `TSPB_ASSERT_NEXT(a_capture_at_frame_end, !captured_r && !(acc && frame_end),
                    !captured_r)
  `TSPB_ASSERT_NEXT(a_plane_step, acc && frame_end,
                    plane_r == PLANE_W'($past(plane_r) + PLANE_W'(1)) && captured_r)

endmodule

// File: dv/tb.sv
module tb;
  import tspb_pkg::*;

  // background is captured over this many positions; later frames never
  // reach a position beyond it, so no uncaptured background is ever read
  localparam int CAPTURE_PIXELS = 16;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_CYCLES    = 100;
  localparam int HOLD_SPACING   = 800;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  // directed capture frame: extremes, primaries, alternating bits
  localparam logic [PIX_W-1:0] CAPTURE_SET [CAPTURE_PIXELS] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
    24'h0000ff, 24'h00ffff, 24'hff00ff, 24'hffff00,
    24'h808080, 24'h7f7f7f, 24'h010101, 24'hfefefe,
    24'haaaaaa, 24'h555555, 24'h123456, 24'hfedcba
  };

  // frame size choices visited in turn by the random phases
  typedef enum int {
    SZ_SMALL,
    SZ_MAX,
    SZ_ONE,
    SZ_CAPTURE,
    SZ_OVER,
    SZ_ZERO,
    SZ_BIG
  } size_kind_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] in_pixel_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_pixel_out;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  temporal_still_pixel_blend u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // pixels waiting to be offered, blended pixels waiting to come out
  logic [PIX_W-1:0] pixel_queue [$];
  logic [PIX_W-1:0] expected_pixels [$];
  logic [PIX_W-1:0] scene [CAPTURE_PIXELS];
  logic [PIX_W-1:0] want_pixel;

  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 53;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  int unsigned hold_mark = 300;
  bit          took_item = 1'b0;

  // predicted block state: per-position luma history, running sums and
  // background, plus the raster position and the history plane
  bit [LUMA_W-1:0] luma_hist [HIST_PLANES][MAX_PIXELS];
  bit [SUM_W-1:0]  luma_total [MAX_PIXELS];
  bit [PIX_W-1:0]  bg_pixel [MAX_PIXELS];
  int unsigned     cur_pos = 0;
  int unsigned     cur_plane = 0;
  bit              bg_done = 1'b0;
  mode_t           cur_mode = MODE_DISAPPEAR;
  int unsigned     cur_frame_pix = FP_RESET;

  // zero acts as one, anything above the store size as the store size
  function automatic int unsigned frame_len(int unsigned fp);
    if (fp == 0) return 1;
    if (fp > MAX_PIXELS) return MAX_PIXELS;
    return fp;
  endfunction

  // from + floor((to - from) * w / 256), arithmetic shift floors negatives
  function automatic logic [7:0] mix(int from, int to, int w);
    int d;
    d = (to - from) * w;
    return 8'(from + (d >>> 8));
  endfunction

  task automatic blend_predict(logic [PIX_W-1:0] px);
    int unsigned pos, luma, total, scaled, diff, w;
    int r, g, b, br, bgg, bb;
    logic [PIX_W-1:0] bg;
    pos = (cur_pos >= MAX_PIXELS) ? 0 : cur_pos;
    // first frame after reset: background follows the live pixel
    if (!bg_done) bg_pixel[pos] = px;
    bg = bg_pixel[pos];
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    br = bg[23:16];
    bgg = bg[15:8];
    bb = bg[7:0];
    luma = (r + 2 * g + b) >> 2;
    // oldest luma for this position leaves the sum, the new one enters
    total = luma_total[pos] - luma_hist[cur_plane][pos] + luma;
    luma_total[pos] = SUM_W'(total);
    luma_hist[cur_plane][pos] = LUMA_W'(luma);
    scaled = luma << HISTORY_LOG2;
    diff = (scaled >= total) ? scaled - total : total - scaled;
    w = (diff << MOTION_GAIN_LOG2) >> HISTORY_LOG2;
    if (w > WEIGHT_MAX) w = WEIGHT_MAX;
    if (cur_mode == MODE_DISAPPEAR)
      expected_pixels.push_back({mix(br, r, w), mix(bgg, g, w), mix(bb, b, w)});
    else
      expected_pixels.push_back({mix(r, br, w), mix(g, bgg, w), mix(b, bb, w)});
    // frame end also fires when the size was lowered below the position
    if (cur_pos + 1 >= frame_len(cur_frame_pix)) begin
      cur_pos = 0;
      cur_plane = (cur_plane + 1) % HIST_PLANES;
      bg_done = 1'b1;
    end else begin
      cur_pos++;
    end
  endtask

  // mostly still content with a little noise, some scene changes, and
  // some pixels with nothing to do with the scene
  function automatic logic [PIX_W-1:0] scene_pixel(int unsigned pos);
    int unsigned pick;
    logic [PIX_W-1:0] px;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      px = scene[pos] ^ PIX_W'($urandom & 32'h030303);
    end else if (pick < 75) begin
      px = scene[pos];
    end else if (pick < 85) begin
      scene[pos] = PIX_W'($urandom);
      px = scene[pos];
    end else begin
      px = PIX_W'($urandom);
    end
    return px;
  endfunction

  // input accept and output check share one process, accept first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        blend_predict(in_pixel_in);
        took_item = 1'b1;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("pixel_out %06h with no item pending", out_pixel_out);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (out_pixel_out !== want_pixel) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("pixel_out: expected %06h, got %06h", want_pixel, out_pixel_out);
          end
        end
      end
    end
  end

  // sender: holds the item until taken, then may idle at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_item) begin
      took_item = 1'b0;
      if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_pixel_in <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold now and then so the
  // pipeline backs up and in_ready drops while items keep coming
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (results_seen >= hold_mark) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + HOLD_SPACING;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // wait until every queued item went in and its pixel came out
  task automatic drain_pipeline();
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(data);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:         cur_mode = mode_t'(data[0]);
      REG_FRAME_PIXELS: cur_frame_pix = data & 32'h7fff;
      default:          ;
    endcase
  endtask

  task automatic apply_settings(mode_t m, int unsigned fp);
    drain_pipeline();
    write_reg(REG_MODE, m);
    write_reg(REG_FRAME_PIXELS, fp);
  endtask

  initial begin
    int unsigned gen_pos, gen_len, fp, count, random_items, phase;
    size_kind_t kind;
    mode_t m;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // capture frame in disappear mode: background equals the live pixel
    apply_settings(MODE_DISAPPEAR, CAPTURE_PIXELS);
    for (int i = 0; i < CAPTURE_PIXELS; i++) begin
      scene[i] = CAPTURE_SET[i];
      pixel_queue.push_back(CAPTURE_SET[i]);
    end

    // appear mode against the inverted background, large weights
    apply_settings(MODE_APPEAR, CAPTURE_PIXELS);
    for (int i = 0; i < 6; i++)
      pixel_queue.push_back(~CAPTURE_SET[i]);

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 25;
      end

      // a small size after a large one catches the position beyond
      // the new frame end
      kind = size_kind_t'(phase % 7);
      case (kind)
        SZ_SMALL:   fp = $urandom_range(2, CAPTURE_PIXELS);
        SZ_MAX:     fp = MAX_PIXELS;
        SZ_ONE:     fp = 1;
        SZ_CAPTURE: fp = CAPTURE_PIXELS;
        SZ_OVER:    fp = $urandom_range(0, 1) ? 32'h7fff : $urandom_range(MAX_PIXELS + 1, 32'h7fff);
        SZ_ZERO:    fp = 0;
        default:    fp = $urandom_range(CAPTURE_PIXELS + 1, MAX_PIXELS - 1);
      endcase
      m = mode_t'($urandom_range(0, 1));
      apply_settings(m, fp);

      // with a frame larger than the captured area, stop short of it
      gen_pos = cur_pos;
      gen_len = frame_len(fp);
      if (gen_len > CAPTURE_PIXELS)
        count = CAPTURE_PIXELS - 1 - gen_pos;
      else
        count = $urandom_range(30, 90);
      repeat (count) begin
        pixel_queue.push_back(scene_pixel(gen_pos));
        if (gen_pos + 1 >= gen_len) gen_pos = 0;
        else gen_pos++;
      end
      random_items += count;
      phase++;
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("temporal_still_pixel_blend: match");
    end else begin
      $display("temporal_still_pixel_blend: mismatch");
    end
    $finish;
  end

  // covers the clearing pass after reset and the slowest stall pattern
  initial begin
    #20000000;
    $display("temporal_still_pixel_blend: mismatch");
    $finish;
  end

endmodule
